// ----- src/morse_key_decoder_macros.svh -----
// ----------------------------------------------------------------------------
// Morse key decoder assertion macros
// Shared property wrappers; every use expects clk and rst in scope.
// ----------------------------------------------------------------------------
`ifndef MORSE_KEY_DECODER_MACROS_SVH
`define MORSE_KEY_DECODER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define MKD_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define MKD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/mkd_pkg.sv -----
// ----------------------------------------------------------------------------
// Morse key decoder package
// Shared constants, types, the Morse pattern table and cursor helpers.
// ----------------------------------------------------------------------------
package mkd_pkg;

  localparam int MAX_SYMBOLS    = 7;
  localparam int SCREEN_COLUMNS = 16;
  localparam int SCREEN_LINES   = 2;

  localparam int SYM_CNT_W    = $clog2(MAX_SYMBOLS + 1);
  localparam int NUM_PATTERNS = 28;

  // Result queue geometry
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Input action codes
  localparam logic ACT_RELEASE = 1'b0;
  localparam logic ACT_TICK    = 1'b1;

  // Result kind codes
  localparam logic KIND_CHAR  = 1'b0;
  localparam logic KIND_CLEAR = 1'b1;

  // Configuration register indexes
  localparam logic [7:0] CFG_DOT_LIMIT  = 8'd0;
  localparam logic [7:0] CFG_LETTER_GAP = 8'd1;
  localparam logic [7:0] CFG_WORD_GAP   = 8'd2;
  localparam logic [7:0] CFG_RESET_DOTS = 8'd3;

  localparam logic [15:0] DOT_LIMIT_RST  = 16'd7828;
  localparam logic [15:0] LETTER_GAP_RST = 16'd95;
  localparam logic [15:0] WORD_GAP_RST   = 16'd262;
  localparam logic [7:0]  RESET_DOTS_RST = 8'd4;

  typedef logic [6:0] char_t;

  localparam char_t CHAR_UNKNOWN = 7'h3F;
  localparam char_t CHAR_PERIOD  = 7'h2E;
  localparam char_t CHAR_HYPHEN  = 7'h2D;
  localparam char_t CHAR_A       = 7'h41;

  // Pattern k: symbol i is a dash when bit i of PAT_BITS is set.
  // Entries A..Z, then period and hyphen.
  localparam int PAT_LEN [NUM_PATTERNS] = '{
    2, 4, 4, 3, 1, 4, 3, 4, 2, 4, 3, 4, 2, 2, 3, 4, 4, 3, 3, 1,
    3, 4, 3, 4, 4, 4, 6, 6
  };
  localparam int PAT_BITS [NUM_PATTERNS] = '{
    2, 1, 5, 1, 0, 4, 3, 0, 0, 14, 5, 2, 3, 1, 7, 6, 11, 2, 0, 1,
    4, 8, 6, 9, 13, 3, 42, 33
  };

  typedef struct packed {
    logic [15:0] dot_limit;
    logic [15:0] letter_space;
    logic [15:0] word_space;
    logic [7:0]  reset_dots;
  } cfg_t;

  typedef struct packed {
    logic [3:0] column;
    logic       line;
  } cursor_t;

  typedef struct packed {
    logic       kind;
    char_t      char_code;
    logic [3:0] column;
    logic       line;
    logic       last;
  } result_t;

  // Results caused by one accepted item: zero, one or two of them
  typedef struct packed {
    logic [1:0] count;
    result_t    r0;
    result_t    r1;
  } push_t;

  function automatic char_t pattern_char(int k);
    char_t ch;
    if (k == NUM_PATTERNS - 2) begin
      ch = CHAR_PERIOD;
    end else if (k == NUM_PATTERNS - 1) begin
      ch = CHAR_HYPHEN;
    end else begin
      ch = CHAR_A + 7'(k);
    end
    return ch;
  endfunction

  function automatic char_t decode_symbols(logic [MAX_SYMBOLS-1:0] bits,
                                           logic [SYM_CNT_W-1:0]   cnt,
                                           logic                   ovf);
    char_t ch;
    ch = CHAR_UNKNOWN;
    if (!ovf && cnt != '0) begin
      for (int k = 0; k < NUM_PATTERNS; k++) begin
        if (int'(cnt) == PAT_LEN[k] && bits == MAX_SYMBOLS'(PAT_BITS[k])) begin
          ch = pattern_char(k);
        end
      end
    end
    return ch;
  endfunction

  // Advance one column, wrapping to the next line and back to the top.
  function automatic cursor_t cursor_step(cursor_t c);
    cursor_t n;
    n = c;
    if (int'(c.column) + 1 >= SCREEN_COLUMNS) begin
      n.column = '0;
      if (int'(c.line) + 1 >= SCREEN_LINES) begin
        n.line = 1'b0;
      end else begin
        n.line = c.line + 1'b1;
      end
    end else begin
      n.column = c.column + 4'd1;
    end
    return n;
  endfunction

endpackage

// ----- src/mkd_core.sv -----
// ----------------------------------------------------------------------------
// Morse key decoder core
// Decoder state and its update for one key release or gap tick.
// ----------------------------------------------------------------------------
`include "morse_key_decoder_macros.svh"

module mkd_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           accept,
  input  logic           action,
  input  logic [15:0]    press_ticks,
  input  mkd_pkg::cfg_t  cfg,
  output mkd_pkg::push_t push
);
  import mkd_pkg::*;

  logic [MAX_SYMBOLS-1:0] symbol_bits, symbol_bits_next;
  logic [SYM_CNT_W-1:0]   symbol_count, symbol_count_next;
  logic                   symbol_overflow, symbol_overflow_next;
  logic [15:0]            gap_counter, gap_counter_next;
  logic                   gap_tracking, gap_tracking_next;
  logic                   letter_pending, letter_pending_next;
  logic                   word_pending, word_pending_next;
  logic [7:0]             dot_run, dot_run_next;
  logic                   has_decoded, has_decoded_next;
  cursor_t                cursor, cursor_next;

  logic                   clr;
  logic                   is_dot;
  logic                   flush;
  cursor_t                c0, c1;
  char_t                  ch;
  logic [MAX_SYMBOLS-1:0] sb;
  logic [SYM_CNT_W-1:0]   sc;
  logic                   so;
  logic [7:0]             dr;
  result_t                char_res, clear_res;

  always_comb begin
    clr    = (dot_run > cfg.reset_dots) && has_decoded;
    is_dot = press_ticks <= cfg.dot_limit;
    flush  = clr || letter_pending;
    c0     = clr ? '0 : cursor;
    c1     = word_pending ? cursor_step(c0) : c0;
    // A clear empties the buffer first, so the letter decodes as unknown
    ch     = clr ? CHAR_UNKNOWN : decode_symbols(symbol_bits, symbol_count, symbol_overflow);

    char_res.kind      = KIND_CHAR;
    char_res.char_code = ch;
    char_res.column    = c1.column;
    char_res.line      = c1.line;
    char_res.last      = 1'b1;

    clear_res.kind      = KIND_CLEAR;
    clear_res.char_code = '0;
    clear_res.column    = '0;
    clear_res.line      = 1'b0;
    clear_res.last      = !letter_pending;

    sb = flush ? '0 : symbol_bits;
    sc = flush ? '0 : symbol_count;
    so = flush ? 1'b0 : symbol_overflow;
    dr = flush ? '0 : dot_run;
    if (!clr) begin
      if (int'(sc) < MAX_SYMBOLS) begin
        sb = sb | (MAX_SYMBOLS'(!is_dot) << sc);
        sc = sc + SYM_CNT_W'(1);
      end else begin
        so = 1'b1;
      end
      if (is_dot && dr != '1) begin
        dr = dr + 8'd1;
      end
    end

    symbol_bits_next     = symbol_bits;
    symbol_count_next    = symbol_count;
    symbol_overflow_next = symbol_overflow;
    gap_counter_next     = gap_counter;
    gap_tracking_next    = gap_tracking;
    letter_pending_next  = letter_pending;
    word_pending_next    = word_pending;
    dot_run_next         = dot_run;
    has_decoded_next     = has_decoded;
    cursor_next          = cursor;
    push                 = '0;
    push.r0              = clr ? clear_res : char_res;
    push.r1              = char_res;

    if (accept) begin
      if (action == ACT_TICK) begin
        if (gap_tracking && gap_counter != '1) begin
          gap_counter_next = gap_counter + 16'd1;
        end
        word_pending_next   = word_pending || (gap_counter_next >= cfg.word_space);
        letter_pending_next = letter_pending || (gap_counter_next >= cfg.letter_space);
      end else begin
        symbol_bits_next     = sb;
        symbol_count_next    = sc;
        symbol_overflow_next = so;
        dot_run_next         = dr;
        gap_counter_next     = '0;
        gap_tracking_next    = !clr || letter_pending;
        letter_pending_next  = 1'b0;
        word_pending_next    = letter_pending ? 1'b0 : word_pending;
        has_decoded_next     = letter_pending ? 1'b1 : (clr ? 1'b0 : has_decoded);
        cursor_next          = letter_pending ? cursor_step(c1) : c0;
        push.count           = 2'(clr) + 2'(letter_pending);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      symbol_bits     <= '0;
      symbol_count    <= '0;
      symbol_overflow <= 1'b0;
      gap_counter     <= '0;
      gap_tracking    <= 1'b0;
      letter_pending  <= 1'b0;
      word_pending    <= 1'b0;
      dot_run         <= '0;
      has_decoded     <= 1'b0;
      cursor          <= '0;
    end else begin
      symbol_bits     <= symbol_bits_next;
      symbol_count    <= symbol_count_next;
      symbol_overflow <= symbol_overflow_next;
      gap_counter     <= gap_counter_next;
      gap_tracking    <= gap_tracking_next;
      letter_pending  <= letter_pending_next;
      word_pending    <= word_pending_next;
      dot_run         <= dot_run_next;
      has_decoded     <= has_decoded_next;
      cursor          <= cursor_next;
    end
  end

  `MKD_ASSERT_NEXT(a_release_zeroes_gap, accept && action == ACT_RELEASE, gap_counter == '0, "gap counter not zeroed by release")
  `MKD_ASSERT_NEXT(a_decode_consumes_letter, accept && action == ACT_RELEASE && letter_pending, !letter_pending && !word_pending && has_decoded, "pending letter not consumed")
  `MKD_ASSERT_IMPLIES(a_clear_result_first, push.count == 2'd2, push.r0.kind == KIND_CLEAR && !push.r0.last && push.r1.last, "two results not ordered clear then char")

endmodule

// ----- src/mkd_queue.sv -----
// ----------------------------------------------------------------------------
// Morse key decoder result queue
// Small FIFO: up to two results in a cycle, one out a cycle while not stalled.
// ----------------------------------------------------------------------------
`include "morse_key_decoder_macros.svh"

module mkd_queue (
  input  logic              clk,
  input  logic              rst,
  input  mkd_pkg::push_t    push,
  input  logic              out_stall,
  output logic              in_stall,
  output logic              out_valid,
  output mkd_pkg::result_t  result
);
  import mkd_pkg::*;

  result_t           mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, wr_ptr_next;
  logic [QPTR_W-1:0] rd_ptr, rd_ptr_next;
  logic [QCNT_W-1:0] count, count_next;
  logic              pop;

  assign out_valid = count != '0;
  assign result    = mem[rd_ptr];
  assign pop       = out_valid && !out_stall;
  // Hold off new input unless two slots are free; also hold during reset
  assign in_stall  = rst || (int'(count) > QDEPTH - 2);

  always_comb begin
    wr_ptr_next = wr_ptr + QPTR_W'(push.count);
    rd_ptr_next = rd_ptr + QPTR_W'(pop);
    count_next  = count + QCNT_W'(push.count) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr] <= push.r0;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr + QPTR_W'(1)] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  `MKD_ASSERT_IMPLIES(a_count_bound, 1'b1, int'(count) <= QDEPTH, "queue count above depth")
  `MKD_ASSERT_IMPLIES(a_no_overfill, push.count != 2'd0, int'(count) + int'(push.count) <= QDEPTH, "push into full queue")
  `MKD_ASSERT_IMPLIES(a_ptr_spacing, 1'b1, QPTR_W'(wr_ptr - rd_ptr) == QPTR_W'(count), "pointers disagree with count")

endmodule

// ----- src/morse_key_decoder.sv -----
// ----------------------------------------------------------------------------
// Morse key decoder
// Turns key releases and gap-timer ticks into decoded characters and screen
// clears with their display position.
// ----------------------------------------------------------------------------
// Takes one item per clock while in_stall is low: each key release or tick
// updates the decoder state and drops its results (none, one, or a clear
// followed by a character) into a four-entry result queue. Results leave the
// queue one per cycle while out_stall is low. in_stall rises while fewer than
// two queue slots are free, and during reset. Configuration writes are taken
// on any cycle (cfg_ready is always high); indexes above 3 are ignored.
module morse_key_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        action,
  input  logic [15:0] press_ticks,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        kind,
  output logic [6:0]  char_code,
  output logic [3:0]  column,
  output logic        line,
  output logic        last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import mkd_pkg::*;

  cfg_t    cfg;
  push_t   push;
  result_t result;
  logic    accept;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dot_limit    <= DOT_LIMIT_RST;
      cfg.letter_space <= LETTER_GAP_RST;
      cfg.word_space   <= WORD_GAP_RST;
      cfg.reset_dots   <= RESET_DOTS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_DOT_LIMIT:  cfg.dot_limit    <= cfg_data;
        CFG_LETTER_GAP: cfg.letter_space <= cfg_data;
        CFG_WORD_GAP:   cfg.word_space   <= cfg_data;
        CFG_RESET_DOTS: cfg.reset_dots   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  mkd_core u_core (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .action      (action),
    .press_ticks (press_ticks),
    .cfg         (cfg),
    .push        (push)
  );

  mkd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .out_stall (out_stall),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .result    (result)
  );

  assign kind      = result.kind;
  assign char_code = result.char_code;
  assign column    = result.column;
  assign line      = result.line;
  assign last      = result.last;

endmodule
